@@ design/srsm_pkg.sv @@
// ============================================================================
// Stick rate servo mixer package
// Shared constants, register indexes and control types for the mixer.
// ============================================================================
package srsm_pkg;

    // Field widths
    localparam int STICK_W  = 11;
    localparam int THRUST_W = 10;
    localparam int BUTTON_W = 16;
    localparam int POS_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int DEG_W    = 8;
    localparam int THR_W    = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 56;

    // Servo centers and flap angles in whole degrees
    localparam int AILERON_CENTER  = 90;
    localparam int ELEVATOR_CENTER = 90;
    localparam int RUDDER_CENTER   = 90;
    localparam logic [DEG_W-1:0] FLAP_UP_DEG   = 8'd0;
    localparam logic [DEG_W-1:0] FLAP_MID_DEG  = 8'd45;
    localparam logic [DEG_W-1:0] FLAP_DOWN_DEG = 8'd90;

    // Centers as Q8.8 positions
    localparam logic [POS_W-1:0] AILERON_POS_CENTER  = POS_W'(AILERON_CENTER * 256);
    localparam logic [POS_W-1:0] ELEVATOR_POS_CENTER = POS_W'(ELEVATOR_CENTER * 256);
    localparam logic [POS_W-1:0] RUDDER_POS_CENTER   = POS_W'(RUDDER_CENTER * 256);

    // Throttle: idle pulse width and divide-by-ten as multiply and shift.
    // x * 205 >> 11 equals x / 10 for every 10-bit x.
    localparam logic [THR_W-1:0] THROTTLE_IDLE_US = 11'd1000;
    localparam logic [7:0]       DIV10_MUL        = 8'd205;
    localparam int               DIV10_SHIFT      = 11;

    // Button bits
    localparam int BTN_ARM       = 0;
    localparam int BTN_FLAP_UP   = 2;
    localparam int BTN_RECENTER  = 3;
    localparam int BTN_FLAP_DOWN = 4;
    localparam int BTN_RELEASE   = 5;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEAD_BAND  = 3'd0,
        REG_PITCH_GAIN = 3'd1,
        REG_ROLL_GAIN  = 3'd2,
        REG_YAW_GAIN   = 3'd3,
        REG_PITCH_MAX  = 3'd4,
        REG_ROLL_MAX   = 3'd5,
        REG_YAW_MAX    = 3'd6
    } reg_index_t;

    // Configuration reset values
    localparam logic [9:0]        DEAD_BAND_RESET = 10'd50;
    localparam logic [GAIN_W-1:0] GAIN_RESET      = 16'd655;
    localparam logic [POS_W-1:0]  MAX_RESET       = 16'd46080;

    // Per-sample control handed to each axis integrator
    typedef struct packed {
        logic advance;
        logic recenter;
    } axis_ctrl_t;

endpackage

@@ design/srsm_axis_rate.sv @@
// ============================================================================
// Stick rate axis integrator
// Holds one Q8.8 servo position and moves it by deadbanded stick times gain,
// clamped to zero and the axis limit, with an optional recenter.
// ============================================================================
module srsm_axis_rate #(
    parameter logic [srsm_pkg::POS_W-1:0] CENTER_POS = srsm_pkg::ELEVATOR_POS_CENTER
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  srsm_pkg::axis_ctrl_t                ctrl,
    input  logic signed [srsm_pkg::STICK_W-1:0] stick,
    input  logic [9:0]                          dead_band,
    input  logic [srsm_pkg::GAIN_W-1:0]         gain,
    input  logic [srsm_pkg::POS_W-1:0]          limit,
    output logic [srsm_pkg::POS_W-1:0]          pos_next
);

    logic [srsm_pkg::POS_W-1:0]   pos_reg;
    logic [srsm_pkg::STICK_W-1:0] mag;
    logic                         live;
    logic [26:0]                  prod;
    logic [17:0]                  step;
    logic signed [19:0]           sum;
    logic [srsm_pkg::POS_W-1:0]   clamped;

    // Magnitude of the stick; the most negative code maps to 1024.
    assign mag  = stick[srsm_pkg::STICK_W-1] ? (~stick + 11'd1) : stick;
    assign live = (mag >= {1'b0, dead_band});

    // Rate step, truncated toward zero on the magnitude.
    assign prod = {16'b0, mag} * {11'b0, gain};
    assign step = live ? prod[25:8] : 18'd0;

    // Signed sum of position and step.
    assign sum = stick[srsm_pkg::STICK_W-1]
               ? ($signed({4'b0, pos_reg}) - $signed({2'b0, step}))
               : ($signed({4'b0, pos_reg}) + $signed({2'b0, step}));

    // Clamp to zero and the limit.
    always_comb
    begin
        priority if (sum[19])
        begin
            clamped = '0;
        end
        else if (sum[18:0] > {3'b0, limit})
        begin
            clamped = limit;
        end
        else
        begin
            clamped = sum[15:0];
        end
    end

    // Recenter overrides the integrated value without clamping.
    assign pos_next = ctrl.recenter ? CENTER_POS : clamped;

    // Position register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= CENTER_POS;
        end
        else if (ctrl.advance)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

@@ design/stick_rate_servo_mixer_unit.sv @@
// ============================================================================
// Stick rate servo mixer
// Turns manual-control samples into servo angles, flap, release, arm and
// throttle pulse width, integrating pitch, roll and yaw into kept positions.
// ============================================================================
// One sample is accepted per clock unless the input side stalls, and each
// sample yields one result through the input register, then the result
// register. The rate is set by the per-axis position update: deadband, one
// multiply, an add, a clamp, closing the loop on each position register. Results
// wait in the output register while new samples keep entering; the input side
// stalls only when both registers are full and the output is not taken.
// Configuration writes are taken in every cycle.
module stick_rate_servo_mixer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input samples
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [10:0] pitch_stick, [21:11] roll_stick, [32:22] yaw_stick,
    // [42:33] thrust_stick, [58:43] button_word, [63:59] zero
    input  logic [srsm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // Results
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] elevator_deg, [15:8] rudder_deg, [23:16] left_aileron_deg,
    // [31:24] right_aileron_deg, [39:32] flaps_deg, [40] release_open,
    // [41] armed_flag, [52:42] throttle_us, [55:53] zero
    output logic [srsm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [srsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srsm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Configuration registers
    logic [9:0]                  dead_band_reg;
    logic [srsm_pkg::GAIN_W-1:0] pitch_gain_reg;
    logic [srsm_pkg::GAIN_W-1:0] roll_gain_reg;
    logic [srsm_pkg::GAIN_W-1:0] yaw_gain_reg;
    logic [srsm_pkg::POS_W-1:0]  pitch_max_reg;
    logic [srsm_pkg::POS_W-1:0]  roll_max_reg;
    logic [srsm_pkg::POS_W-1:0]  yaw_max_reg;

    // Input register
    logic                                in_valid_reg;
    logic signed [srsm_pkg::STICK_W-1:0] pitch_reg;
    logic signed [srsm_pkg::STICK_W-1:0] roll_reg;
    logic signed [srsm_pkg::STICK_W-1:0] yaw_reg;
    logic [srsm_pkg::THRUST_W-1:0]       thrust_reg;
    logic [srsm_pkg::BUTTON_W-1:0]       button_reg;

    // Result register
    logic                                 out_valid_reg;
    logic [srsm_pkg::OUT_DATA_W-1:0]      out_data_reg;
    logic [srsm_pkg::OUT_DATA_W-1:0]      out_data_next;

    // Datapath
    logic                        advance;
    srsm_pkg::axis_ctrl_t        axis_ctrl;
    logic [srsm_pkg::POS_W-1:0]  elevator_pos;
    logic [srsm_pkg::POS_W-1:0]  aileron_pos;
    logic [srsm_pkg::POS_W-1:0]  rudder_pos;
    logic [srsm_pkg::POS_W-1:0]  left_pos;
    logic [srsm_pkg::DEG_W-1:0]  flaps_deg;
    logic [srsm_pkg::THRUST_W-1:0] thrust_live;
    logic [17:0]                 thrust_prod;
    logic [srsm_pkg::THR_W-1:0]  throttle_us;
    logic                        armed;

    // Handshake: the sample in the input register moves on when the result
    // register is free or being emptied.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

    // Configuration register writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_band_reg  <= srsm_pkg::DEAD_BAND_RESET;
            pitch_gain_reg <= srsm_pkg::GAIN_RESET;
            roll_gain_reg  <= srsm_pkg::GAIN_RESET;
            yaw_gain_reg   <= srsm_pkg::GAIN_RESET;
            pitch_max_reg  <= srsm_pkg::MAX_RESET;
            roll_max_reg   <= srsm_pkg::MAX_RESET;
            yaw_max_reg    <= srsm_pkg::MAX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (srsm_pkg::reg_index_t'(cfg_index))
                srsm_pkg::REG_DEAD_BAND:  dead_band_reg  <= cfg_data[9:0];
                srsm_pkg::REG_PITCH_GAIN: pitch_gain_reg <= cfg_data;
                srsm_pkg::REG_ROLL_GAIN:  roll_gain_reg  <= cfg_data;
                srsm_pkg::REG_YAW_GAIN:   yaw_gain_reg   <= cfg_data;
                srsm_pkg::REG_PITCH_MAX:  pitch_max_reg  <= cfg_data;
                srsm_pkg::REG_ROLL_MAX:   roll_max_reg   <= cfg_data;
                srsm_pkg::REG_YAW_MAX:    yaw_max_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            pitch_reg  <= s_axis_tdata[10:0];
            roll_reg   <= s_axis_tdata[21:11];
            yaw_reg    <= s_axis_tdata[32:22];
            thrust_reg <= s_axis_tdata[42:33];
            button_reg <= s_axis_tdata[58:43];
        end
    end

    // Axis integrators
    assign axis_ctrl.advance  = advance;
    assign axis_ctrl.recenter = button_reg[srsm_pkg::BTN_RECENTER];

    srsm_axis_rate #(
        .CENTER_POS (srsm_pkg::ELEVATOR_POS_CENTER)
    ) u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (axis_ctrl),
        .stick     (pitch_reg),
        .dead_band (dead_band_reg),
        .gain      (pitch_gain_reg),
        .limit     (pitch_max_reg),
        .pos_next  (elevator_pos)
    );

    srsm_axis_rate #(
        .CENTER_POS (srsm_pkg::AILERON_POS_CENTER)
    ) u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (axis_ctrl),
        .stick     (roll_reg),
        .dead_band (dead_band_reg),
        .gain      (roll_gain_reg),
        .limit     (roll_max_reg),
        .pos_next  (aileron_pos)
    );

    srsm_axis_rate #(
        .CENTER_POS (srsm_pkg::RUDDER_POS_CENTER)
    ) u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (axis_ctrl),
        .stick     (yaw_reg),
        .dead_band (dead_band_reg),
        .gain      (yaw_gain_reg),
        .limit     (yaw_max_reg),
        .pos_next  (rudder_pos)
    );

    // Left aileron mirrors the right one about the roll limit, floored at zero.
    assign left_pos = (aileron_pos > roll_max_reg) ? '0 : (roll_max_reg - aileron_pos);

    // Flap selection: up wins over down, mid when neither is pressed.
    always_comb
    begin
        priority if (button_reg[srsm_pkg::BTN_FLAP_UP])
        begin
            flaps_deg = srsm_pkg::FLAP_UP_DEG;
        end
        else if (button_reg[srsm_pkg::BTN_FLAP_DOWN])
        begin
            flaps_deg = srsm_pkg::FLAP_DOWN_DEG;
        end
        else
        begin
            flaps_deg = srsm_pkg::FLAP_MID_DEG;
        end
    end

    // Throttle: deadbanded thrust divided by ten, added to idle when armed.
    assign armed       = button_reg[srsm_pkg::BTN_ARM];
    assign thrust_live = (thrust_reg < dead_band_reg) ? '0 : thrust_reg;
    assign thrust_prod = {8'b0, thrust_live} * {10'b0, srsm_pkg::DIV10_MUL};
    assign throttle_us = armed
                       ? (srsm_pkg::THROTTLE_IDLE_US
                          + {4'b0, thrust_prod[17:srsm_pkg::DIV10_SHIFT]})
                       : srsm_pkg::THROTTLE_IDLE_US;

    // Result packing.
    assign out_data_next = {3'b0,
                            throttle_us,
                            armed,
                            button_reg[srsm_pkg::BTN_RELEASE],
                            flaps_deg,
                            aileron_pos[15:8],
                            left_pos[15:8],
                            rudder_pos[15:8],
                            elevator_pos[15:8]};

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
